@@ hdl/scs_pkg.sv @@
package scs_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int NUM_COLORS  = 10;
    localparam int COLOR_W     = $clog2(NUM_COLORS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic [7:0]             chan_t;
    typedef logic [COLOR_W-1:0]     color_t;
    typedef logic [NUM_COLORS-1:0]  mask_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef struct packed {
        color_t ca;
        color_t cb;
        color_t cc;
        logic   three;
        logic   sec_end;
        logic   frm_end;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_t;

endpackage

@@ hdl/scs_if.sv @@
interface scs_pix_if import scs_pkg::*; ();
    logic  valid;
    logic  ready;
    chan_t hue_a;
    chan_t sat_a;
    chan_t val_a;
    chan_t hue_b;
    chan_t sat_b;
    chan_t val_b;
    chan_t hue_c;
    chan_t sat_c;
    chan_t val_c;
    logic  sector_end;
    logic  frame_end;

    modport source (output valid, hue_a, sat_a, val_a, hue_b, sat_b, val_b,
                    hue_c, sat_c, val_c, sector_end, frame_end, input ready);
    modport sink (input valid, hue_a, sat_a, val_a, hue_b, sat_b, val_b,
                  hue_c, sat_c, val_c, sector_end, frame_end, output ready);
endinterface

interface scs_res_if import scs_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  result_kind;
    mask_t mask_a;
    mask_t mask_b;
    mask_t mask_c;
    mask_t frame_key;
    logic  last;

    modport source (output valid, result_kind, mask_a, mask_b, mask_c, frame_key, last,
                    input ready);
    modport sink (input valid, result_kind, mask_a, mask_b, mask_c, frame_key, last,
                  output ready);
endinterface

interface scs_cfg_if import scs_pkg::*; ();
    logic valid;
    logic ready;
    logic frame_mode;

    modport source (output valid, frame_mode, input ready);
    modport sink (input valid, frame_mode, output ready);
endinterface

@@ hdl/sector_color_signature.sv @@
// sector_color_signature: sorts each pixel (frame a, or frames a, b and c when
// frame_mode is 1) into one of ten colors and reports per-sector presence masks
// plus, at frame end, a key of the three most frequent frame-a colors. Pixels
// are taken one per cycle while the queue has room or the input stage is empty;
// a pixel is classified in the input stage, passes a two-entry queue and is
// applied by the back end when popped. A sector end gives one result, a frame end
// two. A frame end holds the back end for the ranking pass, which walks the ten
// histogram counters through one comparator row, and for delivery of the key;
// the input side keeps taking pixels until the queue and input stage fill.
// frame_mode may only be written while the block is idle.
module sector_color_signature import scs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    scs_pix_if.sink   pix,
    scs_cfg_if.sink   cfg,
    scs_res_if.source res
);

    queue_t push;
    logic   push_ready;
    queue_t head;
    logic   pop;

    scs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .cfg        (cfg),
        .push       (push),
        .push_ready (push_ready)
    );

    scs_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    scs_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .res   (res)
    );

endmodule

@@ hdl/scs_front.sv @@
module scs_front import scs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    scs_pix_if.sink       pix,
    scs_cfg_if.sink       cfg,
    output queue_t        push,
    input  logic          push_ready
);

    localparam color_t COLOR_BLACK  = color_t'(0);
    localparam color_t COLOR_WHITE  = color_t'(1);
    localparam color_t COLOR_GREY   = color_t'(2);
    localparam color_t COLOR_RED    = color_t'(3);
    localparam color_t COLOR_ORANGE = color_t'(4);
    localparam color_t COLOR_YELLOW = color_t'(5);
    localparam color_t COLOR_GREEN  = color_t'(6);
    localparam color_t COLOR_CYAN   = color_t'(7);
    localparam color_t COLOR_BLUE   = color_t'(8);
    localparam color_t COLOR_VIOLET = color_t'(9);

    function automatic color_t classify(chan_t h, chan_t s, chan_t v);
        color_t c;
        priority if (v < 8'd75)                c = COLOR_BLACK;
        else if (v > 8'd190 && s < 8'd27)      c = COLOR_WHITE;
        else if (s < 8'd53 && v < 8'd185)      c = COLOR_GREY;
        else if (h < 8'd7)                     c = COLOR_RED;
        else if (h < 8'd25)                    c = COLOR_ORANGE;
        else if (h < 8'd34)                    c = COLOR_YELLOW;
        else if (h < 8'd73)                    c = COLOR_GREEN;
        else if (h < 8'd102)                   c = COLOR_CYAN;
        else if (h < 8'd140)                   c = COLOR_BLUE;
        else if (h < 8'd170)                   c = COLOR_VIOLET;
        else                                   c = COLOR_RED;
        return c;
    endfunction

    logic  mode_reg;
    logic  stage_valid_reg;
    item_t stage_item_reg;
    logic  take;

    assign cfg.ready = 1'b1;
    assign pix.ready = !stage_valid_reg || push_ready;
    assign take      = pix.valid && pix.ready;

    assign push.valid = stage_valid_reg;
    assign push.item  = stage_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                mode_reg <= cfg.frame_mode;
            end
            if (take)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (push_ready)
            begin
                stage_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_item_reg.ca      <= classify(pix.hue_a, pix.sat_a, pix.val_a);
            stage_item_reg.cb      <= classify(pix.hue_b, pix.sat_b, pix.val_b);
            stage_item_reg.cc      <= classify(pix.hue_c, pix.sat_c, pix.val_c);
            stage_item_reg.three   <= mode_reg;
            stage_item_reg.sec_end <= pix.sector_end;
            stage_item_reg.frm_end <= pix.frame_end;
        end
    end

endmodule

@@ hdl/scs_fifo.sv @@
module scs_fifo import scs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  queue_t push,
    output logic   push_ready,
    output queue_t head,
    input  logic   pop
);

    item_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + QUEUE_CNT_W'(1);
                2'b01:   count_reg <= count_reg - QUEUE_CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

@@ hdl/scs_back.sv @@
module scs_back import scs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  queue_t   head,
    output logic     pop,
    scs_res_if.source res
);

    localparam logic KIND_SECTOR = 1'b0;
    localparam logic KIND_KEY    = 1'b1;
    localparam int   RANK_W      = $clog2(NUM_COLORS);

    typedef enum logic [1:0] {
        S_RUN,
        S_RANK,
        S_KEY
    } state_t;

    state_t            state_reg;
    count_t            hist_reg [NUM_COLORS];
    mask_t             pres_a_reg;
    mask_t             pres_b_reg;
    mask_t             pres_c_reg;
    mask_t             key_reg;
    logic [RANK_W-1:0] rank_reg;

    logic  out_valid_reg;
    logic  out_kind_reg;
    mask_t out_a_reg;
    mask_t out_b_reg;
    mask_t out_c_reg;
    mask_t out_key_reg;
    logic  out_last_reg;

    logic              out_free;
    logic              out_load;
    logic              is_end;
    mask_t             pres_a_next;
    mask_t             pres_b_next;
    mask_t             pres_c_next;
    logic [RANK_W-1:0] above;
    logic [RANK_W-1:0] tie_lim;

    assign res.valid       = out_valid_reg;
    assign res.result_kind = out_kind_reg;
    assign res.mask_a      = out_a_reg;
    assign res.mask_b      = out_b_reg;
    assign res.mask_c      = out_c_reg;
    assign res.frame_key   = out_key_reg;
    assign res.last        = out_last_reg;

    assign out_free = !out_valid_reg || res.ready;
    assign is_end   = head.item.sec_end || head.item.frm_end;
    assign pop      = (state_reg == S_RUN) && head.valid && (!is_end || out_free);
    assign out_load = (pop && is_end) || ((state_reg == S_KEY) && out_free);

    assign pres_a_next = pres_a_reg | (mask_t'(1) << head.item.ca);
    assign pres_b_next = head.item.three ? (pres_b_reg | (mask_t'(1) << head.item.cb))
                                         : pres_b_reg;
    assign pres_c_next = head.item.three ? (pres_c_reg | (mask_t'(1) << head.item.cc))
                                         : pres_c_reg;

    // entry 0 holds color rank_reg; entry j holds color (rank_reg + j) mod 10
    assign tie_lim = RANK_W'(NUM_COLORS) - rank_reg;

    always_comb
    begin
        above = '0;
        for (int j = 1; j < NUM_COLORS; j++)
        begin
            if (hist_reg[j] > hist_reg[0] ||
                (hist_reg[j] == hist_reg[0] && RANK_W'(j) < tie_lim))
            begin
                above = above + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            pres_a_reg    <= '0;
            pres_b_reg    <= '0;
            pres_c_reg    <= '0;
            key_reg       <= '0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_SECTOR;
            out_a_reg     <= '0;
            out_b_reg     <= '0;
            out_c_reg     <= '0;
            out_key_reg   <= '0;
            out_last_reg  <= 1'b0;
            for (int j = 0; j < NUM_COLORS; j++)
            begin
                hist_reg[j] <= '0;
            end
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_RUN:
                begin
                    if (pop)
                    begin
                        for (int j = 0; j < NUM_COLORS; j++)
                        begin
                            if (head.item.ca == color_t'(j) && hist_reg[j] != '1)
                            begin
                                hist_reg[j] <= hist_reg[j] + count_t'(1);
                            end
                        end
                        if (is_end)
                        begin
                            out_kind_reg  <= KIND_SECTOR;
                            out_a_reg     <= pres_a_next;
                            out_b_reg     <= head.item.three ? pres_b_next : '0;
                            out_c_reg     <= head.item.three ? pres_c_next : '0;
                            out_key_reg   <= '0;
                            out_last_reg  <= !head.item.frm_end;
                            pres_a_reg    <= '0;
                            pres_b_reg    <= '0;
                            pres_c_reg    <= '0;
                            if (head.item.frm_end)
                            begin
                                state_reg <= S_RANK;
                                rank_reg  <= '0;
                                key_reg   <= '0;
                            end
                        end
                        else
                        begin
                            pres_a_reg <= pres_a_next;
                            pres_b_reg <= pres_b_next;
                            pres_c_reg <= pres_c_next;
                        end
                    end
                end
                S_RANK:
                begin
                    if (above < RANK_W'(3))
                    begin
                        key_reg <= key_reg | (mask_t'(1) << rank_reg);
                    end
                    for (int j = 0; j < NUM_COLORS; j++)
                    begin
                        hist_reg[j] <= hist_reg[(j == NUM_COLORS - 1) ? 0 : j + 1];
                    end
                    if (rank_reg == RANK_W'(NUM_COLORS - 1))
                    begin
                        state_reg <= S_KEY;
                    end
                    else
                    begin
                        rank_reg <= rank_reg + RANK_W'(1);
                    end
                end
                S_KEY:
                begin
                    if (out_free)
                    begin
                        out_kind_reg  <= KIND_KEY;
                        out_a_reg     <= '0;
                        out_b_reg     <= '0;
                        out_c_reg     <= '0;
                        out_key_reg   <= key_reg;
                        out_last_reg  <= 1'b1;
                        state_reg     <= S_RUN;
                        for (int j = 0; j < NUM_COLORS; j++)
                        begin
                            hist_reg[j] <= '0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_RUN;
                end
            endcase
        end
    end

endmodule

@@ test/tb_sector_color_signature.sv @@
`timescale 1ns / 1ps

module tb_sector_color_signature;
    import scs_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 1700;

    localparam logic MODE_ONE     = 1'b0;
    localparam logic MODE_THREE   = 1'b1;
    localparam logic KIND_SECTOR  = 1'b0;
    localparam logic KIND_FRAME   = 1'b1;

    localparam chan_t V_DARK     = 75;
    localparam chan_t V_WHITE    = 190;
    localparam chan_t S_WHITE    = 27;
    localparam chan_t S_GREY     = 53;
    localparam chan_t V_GREY     = 185;
    localparam chan_t H_ORANGE   = 7;
    localparam chan_t H_YELLOW   = 25;
    localparam chan_t H_GREEN    = 34;
    localparam chan_t H_CYAN     = 73;
    localparam chan_t H_BLUE     = 102;
    localparam chan_t H_VIOLET   = 140;
    localparam chan_t H_RED_WRAP = 170;

    typedef enum logic [COLOR_W-1:0] {
        C_BLACK, C_WHITE, C_GREY, C_RED, C_ORANGE,
        C_YELLOW, C_GREEN, C_CYAN, C_BLUE, C_VIOLET
    } tone_e;

    typedef struct {
        chan_t hue_a, sat_a, val_a;
        chan_t hue_b, sat_b, val_b;
        chan_t hue_c, sat_c, val_c;
        logic  sector_end;
        logic  frame_end;
    } pixel_t;

    typedef struct {
        logic  kind;
        mask_t mask_a;
        mask_t mask_b;
        mask_t mask_c;
        mask_t key;
        logic  last;
    } signature_t;

    logic clk = 1'b0;
    logic rst_n;

    scs_pix_if pix ();
    scs_cfg_if cfg ();
    scs_res_if res ();

    sector_color_signature i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .cfg   (cfg),
        .res   (res)
    );

    always
    begin
        #1;
        clk = 1'b1;
        #1;
        clk = 1'b0;
    end

    // predictor state
    logic       cur_mode;
    mask_t      seen_a, seen_b, seen_c;
    count_t     tally [NUM_COLORS];
    signature_t pending_sigs [$];

    int     mismatch_count;
    int     cycle_count;
    int     pixels_sent;
    bit     src_gaps_on;
    int     sink_stall_level;
    pixel_t palette [4];

    function automatic tone_e sort_color(chan_t h, chan_t s, chan_t v);
        if (v < V_DARK) return C_BLACK;
        if (v > V_WHITE && s < S_WHITE) return C_WHITE;
        if (s < S_GREY && v < V_GREY) return C_GREY;
        if (h < H_ORANGE) return C_RED;
        if (h < H_YELLOW) return C_ORANGE;
        if (h < H_GREEN) return C_YELLOW;
        if (h < H_CYAN) return C_GREEN;
        if (h < H_BLUE) return C_CYAN;
        if (h < H_VIOLET) return C_BLUE;
        if (h < H_RED_WRAP) return C_VIOLET;
        return C_RED;
    endfunction

    function automatic mask_t top_three_key();
        mask_t key;
        int    above;
        key = '0;
        for (int i = 0; i < NUM_COLORS; i++)
        begin
            above = 0;
            for (int j = 0; j < NUM_COLORS; j++)
            begin
                if (j != i && (tally[j] > tally[i] || (tally[j] == tally[i] && j > i)))
                    above++;
            end
            if (above < 3)
                key[i] = 1'b1;
        end
        return key;
    endfunction

    function automatic void apply_pixel(pixel_t p);
        tone_e      ca;
        signature_t sig;
        ca = sort_color(p.hue_a, p.sat_a, p.val_a);
        seen_a |= mask_t'(1) << ca;
        if (cur_mode == MODE_THREE)
        begin
            seen_b |= mask_t'(1) << sort_color(p.hue_b, p.sat_b, p.val_b);
            seen_c |= mask_t'(1) << sort_color(p.hue_c, p.sat_c, p.val_c);
        end
        if (tally[ca] != {COUNT_WIDTH{1'b1}})
            tally[ca] = tally[ca] + count_t'(1);
        if (p.sector_end || p.frame_end)
        begin
            sig.kind   = KIND_SECTOR;
            sig.mask_a = seen_a;
            sig.mask_b = (cur_mode == MODE_THREE) ? seen_b : '0;
            sig.mask_c = (cur_mode == MODE_THREE) ? seen_c : '0;
            sig.key    = '0;
            sig.last   = !p.frame_end;
            pending_sigs.push_back(sig);
            seen_a = '0;
            seen_b = '0;
            seen_c = '0;
        end
        if (p.frame_end)
        begin
            sig.kind   = KIND_FRAME;
            sig.mask_a = '0;
            sig.mask_b = '0;
            sig.mask_c = '0;
            sig.key    = top_three_key();
            sig.last   = 1'b1;
            pending_sigs.push_back(sig);
            for (int i = 0; i < NUM_COLORS; i++)
                tally[i] = '0;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic chan_t rand_hue();
        if ($urandom_range(0, 9) == 0)
            return chan_t'($urandom_range(0, 255));
        return chan_t'($urandom_range(0, 179));
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p.hue_a = rand_hue();
        p.sat_a = chan_t'($urandom_range(0, 255));
        p.val_a = chan_t'($urandom_range(0, 255));
        p.hue_b = rand_hue();
        p.sat_b = chan_t'($urandom_range(0, 255));
        p.val_b = chan_t'($urandom_range(0, 255));
        p.hue_c = rand_hue();
        p.sat_c = chan_t'($urandom_range(0, 255));
        p.val_c = chan_t'($urandom_range(0, 255));
        p.sector_end = 1'b0;
        p.frame_end  = 1'b0;
        return p;
    endfunction

    function automatic pixel_t hsv_pixel(int h, int s, int v, logic se, logic fe);
        pixel_t p;
        p = rand_pixel();
        p.hue_a = chan_t'(h);
        p.sat_a = chan_t'(s);
        p.val_a = chan_t'(v);
        p.sector_end = se;
        p.frame_end  = fe;
        return p;
    endfunction

    function automatic void check_field(string name, mask_t want, mask_t got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // all tasks below start and end just after a falling edge
    task automatic send_pixel(pixel_t p);
        int gap;
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            pix.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix.hue_a      = p.hue_a;
        pix.sat_a      = p.sat_a;
        pix.val_a      = p.val_a;
        pix.hue_b      = p.hue_b;
        pix.sat_b      = p.sat_b;
        pix.val_b      = p.val_b;
        pix.hue_c      = p.hue_c;
        pix.sat_c      = p.sat_c;
        pix.val_c      = p.val_c;
        pix.sector_end = p.sector_end;
        pix.frame_end  = p.frame_end;
        pix.valid      = 1'b1;
        do
            @(posedge clk);
        while (!pix.ready);
        apply_pixel(p);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle(int extra);
        pix.valid = 1'b0;
        while (pending_sigs.size() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_frame_mode(logic mode);
        cfg.frame_mode = mode;
        cfg.valid      = 1'b1;
        do
            @(posedge clk);
        while (!cfg.ready);
        cur_mode = mode;
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic send_color(int h, int s, int v, logic se, logic fe);
        send_pixel(hsv_pixel(h, s, v, se, fe));
    endtask

    task automatic test_color_thresholds();
        write_frame_mode(MODE_ONE);
        send_color(0, 0, 0, 1'b0, 1'b0);
        send_color(179, 255, 74, 1'b0, 1'b0);
        send_color(0, 26, 191, 1'b0, 1'b0);
        send_color(0, 26, 190, 1'b1, 1'b0);
        send_color(90, 27, 255, 1'b0, 1'b0);
        send_color(50, 52, 184, 1'b0, 1'b0);
        send_color(50, 53, 184, 1'b1, 1'b0);
        send_color(6, 255, 255, 1'b0, 1'b0);
        send_color(7, 255, 255, 1'b0, 1'b0);
        send_color(24, 200, 200, 1'b0, 1'b0);
        send_color(25, 200, 200, 1'b0, 1'b0);
        send_color(33, 200, 200, 1'b0, 1'b0);
        send_color(34, 200, 200, 1'b1, 1'b0);
        send_color(72, 200, 200, 1'b0, 1'b0);
        send_color(73, 200, 200, 1'b0, 1'b0);
        send_color(101, 200, 200, 1'b0, 1'b0);
        send_color(102, 200, 200, 1'b0, 1'b0);
        send_color(139, 200, 200, 1'b0, 1'b0);
        send_color(140, 200, 200, 1'b0, 1'b0);
        send_color(169, 200, 200, 1'b0, 1'b0);
        send_color(170, 200, 200, 1'b0, 1'b0);
        send_color(255, 255, 255, 1'b1, 1'b0);
        // frame end without sector end still closes the sector
        send_color(180, 255, 75, 1'b0, 1'b1);
        wait_idle(SETTLE_CYCLES);
    endtask

    task automatic test_three_frames();
        pixel_t p;
        write_frame_mode(MODE_THREE);
        p = hsv_pixel(0, 0, 0, 1'b1, 1'b0);
        p.hue_b = 8'd255; p.sat_b = 8'd255; p.val_b = 8'd255;
        p.hue_c = 8'd100; p.sat_c = 8'd20;  p.val_c = 8'd100;
        send_pixel(p);
        p = hsv_pixel(5, 200, 200, 1'b0, 1'b0);
        p.hue_b = 8'd30;  p.sat_b = 8'd200; p.val_b = 8'd200;
        p.hue_c = 8'd150; p.sat_c = 8'd200; p.val_c = 8'd200;
        send_pixel(p);
        p = hsv_pixel(120, 255, 255, 1'b0, 1'b1);
        p.hue_b = 8'd179; p.sat_b = 8'd0;   p.val_b = 8'd255;
        p.hue_c = 8'd0;   p.sat_c = 8'd255; p.val_c = 8'd74;
        send_pixel(p);
        wait_idle(SETTLE_CYCLES);
    endtask

    task automatic test_mode_switch_in_sector();
        pixel_t p;
        // b and c gathered in mode 1, dropped when the sector ends in mode 0
        p = hsv_pixel(60, 200, 200, 1'b0, 1'b0);
        p.hue_b = 8'd120; p.sat_b = 8'd200; p.val_b = 8'd200;
        send_pixel(p);
        wait_idle(SETTLE_CYCLES);
        write_frame_mode(MODE_ONE);
        send_color(10, 200, 200, 1'b1, 1'b0);
        // b and c of mode 0 pixels never count
        send_color(90, 200, 200, 1'b0, 1'b0);
        wait_idle(SETTLE_CYCLES);
        write_frame_mode(MODE_THREE);
        send_color(150, 200, 200, 1'b1, 1'b0);
        send_color(30, 200, 200, 1'b0, 1'b1);
        wait_idle(SETTLE_CYCLES);
    endtask

    task automatic send_random_frame();
        int     sectors;
        int     len;
        pixel_t p;
        for (int i = 0; i < 4; i++)
            palette[i] = rand_pixel();
        sectors = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 6);
        for (int s = 0; s < sectors; s++)
        begin
            len = (sectors == 1 && $urandom_range(0, 1) == 0) ? 1 : $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
            begin
                p = ($urandom_range(0, 1) == 0) ? palette[$urandom_range(0, 3)] : rand_pixel();
                p.sector_end = (k == len - 1);
                p.frame_end  = 1'b0;
                if (s == sectors - 1 && k == len - 1)
                begin
                    p.frame_end  = 1'b1;
                    p.sector_end = 1'($urandom_range(0, 1));
                end
                if ($urandom_range(0, 49) == 0)
                begin
                    p.sector_end = 1'($urandom_range(0, 1));
                    p.frame_end  = ($urandom_range(0, 9) == 0);
                end
                send_pixel(p);
            end
        end
    endtask

    task automatic run_random_phase(logic mode, int items, bit gaps, int stall_level);
        int start;
        int held;
        wait_idle(SETTLE_CYCLES);
        write_frame_mode(mode);
        src_gaps_on      = gaps;
        sink_stall_level = stall_level;
        start = pixels_sent;
        held  = 0;
        while (pixels_sent - start < items)
        begin
            send_random_frame();
            if (!held && pixels_sent - start >= items / 2)
            begin
                wait_idle(0);
                held = 1;
            end
        end
    endtask

    task automatic test_random_traffic();
        int share;
        share = RANDOM_ITEMS / 6;
        run_random_phase(MODE_ONE, share, 1'b1, 1);
        run_random_phase(MODE_THREE, share, 1'b1, 1);
        run_random_phase(MODE_THREE, share, 1'b0, 0);
        run_random_phase(MODE_ONE, share, 1'b1, 2);
        run_random_phase(MODE_THREE, share, 1'b1, 2);
        run_random_phase(MODE_ONE, share, 1'b0, 1);
        src_gaps_on      = 1'b1;
        sink_stall_level = 1;
    endtask

    // result sink ready with random stalls
    initial
    begin : sink_ready_drive
        int stall_left;
        int chance;
        res.ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                res.ready = 1'b1;
                chance = (sink_stall_level == 2) ? 60 : (sink_stall_level == 1) ? 20 : 0;
                if ($urandom_range(0, 99) < chance)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        signature_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_sigs.size() == 0)
            begin
                $error("result transfer with nothing expected");
                mismatch_count++;
            end
            else
            begin
                want = pending_sigs.pop_front();
                check_field("result_kind", mask_t'(want.kind), mask_t'(res.result_kind));
                check_field("mask_a", want.mask_a, res.mask_a);
                check_field("mask_b", want.mask_b, res.mask_b);
                check_field("mask_c", want.mask_c, res.mask_c);
                check_field("frame_key", want.key, res.frame_key);
                check_field("last", mask_t'(want.last), mask_t'(res.last));
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        pix.valid        = 1'b0;
        pix.hue_a        = '0;
        pix.sat_a        = '0;
        pix.val_a        = '0;
        pix.hue_b        = '0;
        pix.sat_b        = '0;
        pix.val_b        = '0;
        pix.hue_c        = '0;
        pix.sat_c        = '0;
        pix.val_c        = '0;
        pix.sector_end   = 1'b0;
        pix.frame_end    = 1'b0;
        cfg.valid        = 1'b0;
        cfg.frame_mode   = MODE_ONE;
        cur_mode         = MODE_ONE;
        seen_a           = '0;
        seen_b           = '0;
        seen_c           = '0;
        for (int i = 0; i < NUM_COLORS; i++)
            tally[i] = '0;
        mismatch_count   = 0;
        pixels_sent      = 0;
        src_gaps_on      = 1'b1;
        sink_stall_level = 1;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_color_thresholds();
        test_three_frames();
        test_mode_switch_in_sector();
        test_random_traffic();

        wait_idle(SETTLE_CYCLES);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
